/* design/ple_pkg.sv */
// Shared types and constants for the positional list engine
`default_nettype none

package ple_pkg;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_DUMP      = 3'd6
    } ple_act_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } ple_status_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_INS  = 2'd1,
        SH_DEL  = 2'd2,
        SH_ROT  = 2'd3
    } ple_shift_t;

    typedef enum logic {
        STATE_IDLE = 1'b0,
        STATE_DUMP = 1'b1
    } ple_state_t;

    typedef struct packed {
        ple_shift_t             kind;
        logic [IDX_W-1:0]       idx;
    } ple_ctl_t;

endpackage

`default_nettype wire

/* design/ple_req_if.sv */
// Request channel interface of the positional list engine
`default_nettype none

interface ple_req_if
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [DATA_WIDTH-1:0]  value;
    logic [POS_W-1:0]       position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface

`default_nettype wire

/* design/ple_rsp_if.sv */
// Result channel interface of the positional list engine
`default_nettype none

interface ple_rsp_if
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_W-1:0]     count;
    logic [DATA_WIDTH-1:0]  data;
    logic                   data_valid;
    logic                   last;

    modport source (output valid, output status, output count, output data,
                    output data_valid, output last, input ready);
    modport sink   (input valid, input status, input count, input data,
                    input data_valid, input last, output ready);
endinterface

`default_nettype wire

/* design/ple_cell.sv */
// One storage cell of the shifting list chain
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
)
(
    input  logic                    clk,
    input  ple_ctl_t                ctl,
    input  logic [DATA_WIDTH-1:0]   bcast,
    input  logic [DATA_WIDTH-1:0]   left,
    input  logic [DATA_WIDTH-1:0]   right,
    output logic [DATA_WIDTH-1:0]   data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.kind)
            SH_INS:
            begin
                if (MY_IDX > ctl.idx)
                begin
                    data_next = left;
                end
                else if (MY_IDX == ctl.idx)
                begin
                    data_next = bcast;
                end
            end
            SH_DEL:
            begin
                if (MY_IDX >= ctl.idx)
                begin
                    data_next = right;
                end
            end
            SH_ROT:
            begin
                if (MY_IDX == ctl.idx)
                begin
                    data_next = bcast;
                end
                else if (MY_IDX < ctl.idx)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* design/positional_list_engine.sv */
// Top level of the positional list engine: request control and cell chain
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | action, value, position
//  rsp     | out | valid/ready  | status, count, data, data_valid, last
//
// Insert, delete, empty dump: result registered at accept, next one taken once rsp slot is
// free; insert and delete shift the cells from the target on together. Dump of n entries:
// n results after accept; the chain rotates one place per result, so the head cell always drives the data.
// rst_n clears the count, the control state and the result valid; cell contents
// stay undefined. A stalled rsp holds the result register and pauses a dump.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    ple_req_if.sink     req,
    ple_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ple_state_t             state_reg,  state_next;
    logic [CNT_W-1:0]       cnt_reg,    cnt_next;
    logic [CNT_W-1:0]       k_reg,      k_next;
    logic                   ovalid_reg, ovalid_next;
    ple_status_t            ostat_reg,  ostat_next;
    logic [COUNT_W-1:0]     ocount_reg, ocount_next;
    logic [DATA_WIDTH-1:0]  odata_reg,  odata_next;
    logic                   odv_reg,    odv_next;
    logic                   olast_reg,  olast_next;

    ple_ctl_t               ctl;
    logic [DATA_WIDTH-1:0]  bcast;
    logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]  head;

    logic                   slot_free;
    logic                   accept;

    assign head      = cell_data[0];
    assign slot_free = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == STATE_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        logic [IDX_W-1:0]   cnt_w;
        logic [IDX_W-1:0]   pos_w;
        logic [IDX_W-1:0]   tgt;
        logic [IDX_W-1:0]   new_cnt;
        logic               bad;
        logic               fin;

        cnt_w   = IDX_W'(cnt_reg);
        pos_w   = IDX_W'(req.position);
        tgt     = '0;
        new_cnt = cnt_w;
        bad     = 1'b0;
        fin     = 1'b0;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        ostat_next  = ostat_reg;
        ocount_next = ocount_reg;
        odata_next  = odata_reg;
        odv_next    = odv_reg;
        olast_next  = olast_reg;
        ctl.kind    = SH_NONE;
        ctl.idx     = '0;
        bcast       = req.value;

        unique case (state_reg)
            STATE_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action) inside
                        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
                        begin
                            ovalid_next = 1'b1;
                            odata_next  = '0;
                            odv_next    = 1'b0;
                            olast_next  = 1'b1;
                            if (req.action == ACT_INS_FRONT)
                            begin
                                tgt = '0;
                            end
                            else if (req.action == ACT_INS_BACK)
                            begin
                                tgt = cnt_w;
                            end
                            else
                            begin
                                tgt = pos_w - IDX_W'(1);
                                bad = (pos_w == '0) || (pos_w > cnt_w + IDX_W'(1));
                            end
                            if (cnt_w == IDX_W'(CAPACITY))
                            begin
                                ostat_next = STAT_FULL;
                            end
                            else if (bad)
                            begin
                                ostat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ostat_next = STAT_OK;
                                new_cnt    = cnt_w + IDX_W'(1);
                                ctl.kind   = SH_INS;
                                ctl.idx    = tgt;
                            end
                            cnt_next    = new_cnt[CNT_W-1:0];
                            ocount_next = new_cnt[COUNT_W-1:0];
                        end
                        ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
                        begin
                            ovalid_next = 1'b1;
                            odata_next  = '0;
                            odv_next    = 1'b0;
                            olast_next  = 1'b1;
                            if (req.action == ACT_DEL_FRONT)
                            begin
                                tgt = '0;
                            end
                            else if (req.action == ACT_DEL_BACK)
                            begin
                                tgt = cnt_w - IDX_W'(1);
                            end
                            else
                            begin
                                tgt = pos_w - IDX_W'(1);
                                bad = (pos_w == '0) || (pos_w > cnt_w);
                            end
                            if (cnt_w == '0)
                            begin
                                ostat_next = STAT_EMPTY;
                            end
                            else if (bad)
                            begin
                                ostat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ostat_next = STAT_OK;
                                new_cnt    = cnt_w - IDX_W'(1);
                                ctl.kind   = SH_DEL;
                                ctl.idx    = tgt;
                            end
                            cnt_next    = new_cnt[CNT_W-1:0];
                            ocount_next = new_cnt[COUNT_W-1:0];
                        end
                        ACT_DUMP:
                        begin
                            if (cnt_w == '0)
                            begin
                                ovalid_next = 1'b1;
                                ostat_next  = STAT_EMPTY;
                                ocount_next = '0;
                                odata_next  = '0;
                                odv_next    = 1'b0;
                                olast_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = STATE_DUMP;
                                k_next     = '0;
                            end
                        end
                        default:
                        begin
                            state_next = STATE_IDLE;
                        end
                    endcase
                end
            end
            STATE_DUMP:
            begin
                if (slot_free)
                begin
                    fin         = (k_reg == cnt_reg - CNT_W'(1));
                    ctl.kind    = SH_ROT;
                    ctl.idx     = cnt_w - IDX_W'(1);
                    bcast       = head;
                    ovalid_next = 1'b1;
                    ostat_next  = STAT_OK;
                    ocount_next = cnt_w[COUNT_W-1:0];
                    odata_next  = head;
                    odv_next    = 1'b1;
                    olast_next  = fin;
                    k_next      = k_reg + CNT_W'(1);
                    if (fin)
                    begin
                        state_next = STATE_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_IDLE;
            cnt_reg    <= '0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ostat_reg  <= ostat_next;
        ocount_reg <= ocount_next;
        odata_reg  <= odata_next;
        odv_reg    <= odv_next;
        olast_reg  <= olast_next;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_in;
        logic [DATA_WIDTH-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = bcast;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .bcast  (bcast),
            .left   (left_in),
            .right  (right_in),
            .data   (cell_data[i])
        );
    end

    assign rsp.valid      = ovalid_reg;
    assign rsp.status     = ostat_reg;
    assign rsp.count      = ocount_reg;
    assign rsp.data       = odata_reg;
    assign rsp.data_valid = odv_reg;
    assign rsp.last       = olast_reg;

endmodule

`default_nettype wire
